[rtl/lta_pkg.sv]
// shared types, constants and the microcode program of the lottery ticket arbiter
package lta_pkg;

  localparam int SLOTS_DEF       = 16;
  localparam int TICKET_BITS_DEF = 16;
  localparam int SLOT_W          = 4;
  localparam int AMOUNT_W        = 16;
  localparam int RND_W           = 31;
  localparam int BIT_W           = 5;
  localparam int PC_W            = 4;

  typedef logic [PC_W-1:0] pc_t;

  localparam logic [1:0] OP_WRITE    = 2'd0;
  localparam logic [1:0] OP_TRANSFER = 2'd1;
  localparam logic [1:0] OP_DRAW     = 2'd2;

  // microcode addresses
  localparam pc_t PC_WR_ENTRY = 4'd0;
  localparam pc_t PC_XF_RDSRC = 4'd1;
  localparam pc_t PC_XF_LDSRC = 4'd2;
  localparam pc_t PC_XF_WRSRC = 4'd3;
  localparam pc_t PC_XF_WRDST = 4'd4;
  localparam pc_t PC_DR_PRIME = 4'd5;
  localparam pc_t PC_DR_SUM   = 4'd6;
  localparam pc_t PC_DR_CHECK = 4'd7;
  localparam pc_t PC_DR_MOD   = 4'd8;
  localparam pc_t PC_DR_PRIM2 = 4'd9;
  localparam pc_t PC_DR_SCAN  = 4'd10;
  localparam pc_t PC_NOP_END  = 4'd11;

  typedef enum logic [3:0] {
    DP_NOP, DP_WRITE, DP_LOAD_SRC, DP_WR_SRC, DP_WR_DST,
    DP_SCAN_INIT, DP_SUM, DP_MOD_INIT, DP_MOD_STEP, DP_PICK
  } dp_op_t;

  typedef enum logic [1:0] {RA_ZERO, RA_SA, RA_SB, RA_NEXT} rd_sel_t;

  typedef enum logic [1:0] {JMP_NONE, JMP_NOT_LAST, JMP_BIT_MORE} jmp_t;

  typedef enum logic [2:0] {
    END_NEVER, END_ALWAYS, END_BAD_SLOT, END_SRC_ZERO, END_TOTAL_ZERO, END_HIT
  } end_t;

  typedef struct packed {
    dp_op_t  op;
    rd_sel_t rd;
    jmp_t    jmp;
    pc_t     target;
    end_t    fin;
  } ucode_t;

  typedef struct packed {
    logic bad_slot;
    logic src_zero;
    logic total_zero;
    logic not_last;
    logic bit_more;
    logic hit;
  } status_t;

  localparam ucode_t UCODE_NOP = '{DP_NOP, RA_ZERO, JMP_NONE, PC_WR_ENTRY, END_NEVER};

  function automatic pc_t entry_pc(logic [1:0] op);
    pc_t pc;
    unique case (op)
      OP_WRITE:    pc = PC_WR_ENTRY;
      OP_TRANSFER: pc = PC_XF_RDSRC;
      OP_DRAW:     pc = PC_DR_PRIME;
      default:     pc = PC_NOP_END;
    endcase
    return pc;
  endfunction

  function automatic ucode_t ucode_rom(pc_t pc);
    ucode_t w;
    unique case (pc)
      PC_WR_ENTRY: w = '{DP_WRITE,     RA_ZERO, JMP_NONE,     PC_WR_ENTRY, END_ALWAYS};
      PC_XF_RDSRC: w = '{DP_NOP,       RA_SA,   JMP_NONE,     PC_WR_ENTRY, END_BAD_SLOT};
      PC_XF_LDSRC: w = '{DP_LOAD_SRC,  RA_SB,   JMP_NONE,     PC_WR_ENTRY, END_SRC_ZERO};
      PC_XF_WRSRC: w = '{DP_WR_SRC,    RA_ZERO, JMP_NONE,     PC_WR_ENTRY, END_NEVER};
      PC_XF_WRDST: w = '{DP_WR_DST,    RA_ZERO, JMP_NONE,     PC_WR_ENTRY, END_ALWAYS};
      PC_DR_PRIME: w = '{DP_SCAN_INIT, RA_ZERO, JMP_NONE,     PC_WR_ENTRY, END_NEVER};
      PC_DR_SUM:   w = '{DP_SUM,       RA_NEXT, JMP_NOT_LAST, PC_DR_SUM,   END_NEVER};
      PC_DR_CHECK: w = '{DP_MOD_INIT,  RA_ZERO, JMP_NONE,     PC_WR_ENTRY, END_TOTAL_ZERO};
      PC_DR_MOD:   w = '{DP_MOD_STEP,  RA_ZERO, JMP_BIT_MORE, PC_DR_MOD,   END_NEVER};
      PC_DR_PRIM2: w = '{DP_SCAN_INIT, RA_ZERO, JMP_NONE,     PC_WR_ENTRY, END_NEVER};
      PC_DR_SCAN:  w = '{DP_PICK,      RA_NEXT, JMP_NOT_LAST, PC_DR_SCAN,  END_HIT};
      default:     w = '{DP_NOP,       RA_ZERO, JMP_NONE,     PC_WR_ENTRY, END_ALWAYS};
    endcase
    return w;
  endfunction

endpackage

[rtl/lta_sequencer.sv]
// step counter and control store that run one microprogram per transaction
module lta_sequencer
  import lta_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] operation,
  input  status_t    status,
  output ucode_t     ctrl,
  output logic       busy,
  output logic       done
);

  pc_t    pc_r, pc_nxt;
  logic   running_r, running_nxt;
  logic   done_r;
  ucode_t word;
  logic   fin;
  logic   take;

  always_comb begin
    word = ucode_rom(pc_r);
    unique case (word.fin)
      END_NEVER:      fin = 1'b0;
      END_ALWAYS:     fin = 1'b1;
      END_BAD_SLOT:   fin = status.bad_slot;
      END_SRC_ZERO:   fin = status.src_zero;
      END_TOTAL_ZERO: fin = status.total_zero;
      END_HIT:        fin = status.hit;
      default:        fin = 1'b1;
    endcase
    unique case (word.jmp)
      JMP_NONE:     take = 1'b0;
      JMP_NOT_LAST: take = status.not_last;
      JMP_BIT_MORE: take = status.bit_more;
      default:      take = 1'b0;
    endcase
  end

  always_comb begin
    running_nxt = running_r;
    pc_nxt      = pc_r;
    if (!running_r) begin
      if (start) begin
        running_nxt = 1'b1;
        pc_nxt      = entry_pc(operation);
      end
    end else if (fin) begin
      running_nxt = 1'b0;
    end else if (take) begin
      pc_nxt = word.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      running_r <= running_nxt;
      done_r    <= running_r && fin;
    end
  end

  always_ff @(posedge clk) begin
    pc_r <= pc_nxt;
  end

  assign ctrl = running_r ? word : UCODE_NOP;
  assign busy = running_r;
  assign done = done_r;

endmodule

[rtl/lta_datapath.sv]
// ticket table, mark flags, accumulator and serial modulo unit
module lta_datapath
  import lta_pkg::*;
#(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int TICKET_BITS = TICKET_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [SLOT_W-1:0]   slot_a,
  input  logic [SLOT_W-1:0]   slot_b,
  input  logic [AMOUNT_W-1:0] ticket_amount,
  input  logic                entry_present,
  input  logic                entry_runnable,
  input  logic [RND_W-1:0]    random_value,
  input  ucode_t              ctrl,
  output status_t             status,
  output logic [SLOT_W-1:0]   winner_slot,
  output logic                winner_found,
  output logic [AMOUNT_W-1:0] moved_tickets
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int TOT_W = TICKET_BITS + $clog2(SLOTS);
  localparam int AMT_W = (TICKET_BITS > AMOUNT_W) ? TICKET_BITS : AMOUNT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef logic [TICKET_BITS-1:0] ticket_t;

  // latched transaction
  logic [SLOT_W-1:0]   sa_r, sb_r;
  logic [AMOUNT_W-1:0] amt_r;
  logic                pres_r, runb_r;
  logic [RND_W-1:0]    rnd_r;

  // table storage
  ticket_t          mem [SLOTS];
  logic [SLOTS-1:0] valid_r;
  logic [SLOTS-1:0] present_r;
  logic [SLOTS-1:0] runnable_r;
  ticket_t          rdata_r;
  logic             rd_valid_r;
  ticket_t          rdata;

  // working registers
  ticket_t          src_r, mv_r, dst_r;
  logic [IDX_W-1:0] idx_r;
  logic [TOT_W-1:0] acc_r, rem_r;
  logic [BIT_W-1:0] bit_r;

  logic [SLOT_W-1:0]   res_slot_r;
  logic                res_found_r;
  logic [AMOUNT_W-1:0] res_moved_r;

  logic             sa_ok, sb_ok;
  logic [IDX_W-1:0] sa_idx, sb_idx, next_idx, ra;
  logic             we;
  logic [IDX_W-1:0] wa;
  ticket_t          wd;
  ticket_t          src_left, mv_new, sat_sum;
  logic [TICKET_BITS:0] dst_sum;
  logic [TOT_W-1:0] add_val, run_new;
  logic [TOT_W:0]   shifted;
  logic             elig;

  assign sa_ok    = 32'(sa_r) < SLOTS;
  assign sb_ok    = 32'(sb_r) < SLOTS;
  assign sa_idx   = IDX_W'(sa_r);
  assign sb_idx   = IDX_W'(sb_r);
  assign next_idx = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
  assign rdata    = rd_valid_r ? rdata_r : '0;
  assign elig     = present_r[idx_r] & runnable_r[idx_r];

  assign src_left = src_r - mv_r;
  assign mv_new   = (AMT_W'(amt_r) > AMT_W'(rdata)) ? rdata - 1'b1 : TICKET_BITS'(amt_r);
  assign dst_sum  = {1'b0, dst_r} + {1'b0, mv_r};
  assign sat_sum  = dst_sum[TICKET_BITS] ? '1 : dst_sum[TICKET_BITS-1:0];
  assign add_val  = elig ? TOT_W'(rdata) : '0;
  assign run_new  = acc_r + add_val;
  assign shifted  = {rem_r, rnd_r[RND_W-1]};

  always_comb begin
    unique case (ctrl.rd)
      RA_ZERO: ra = '0;
      RA_SA:   ra = sa_idx;
      RA_SB:   ra = sb_idx;
      RA_NEXT: ra = next_idx;
      default: ra = '0;
    endcase
  end

  always_comb begin
    we = 1'b0;
    wa = sa_idx;
    wd = src_left;
    unique case (ctrl.op)
      DP_WRITE: begin
        we = sa_ok;
        wd = TICKET_BITS'(amt_r);
      end
      DP_WR_SRC: begin
        we = 1'b1;
      end
      DP_WR_DST: begin
        we = 1'b1;
        wa = sb_idx;
        wd = sat_sum;
      end
      default: we = 1'b0;
    endcase
  end

  always_comb begin
    status.bad_slot   = !(sa_ok && sb_ok);
    status.src_zero   = (rdata == '0);
    status.total_zero = (acc_r == '0);
    status.not_last   = (idx_r != LAST_IDX);
    status.bit_more   = (bit_r != '0);
    status.hit        = elig && (rem_r < run_new);
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r    <= mem[ra];
    rd_valid_r <= valid_r[ra];
  end

  // valid flags make the whole table read as zero right after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      present_r  <= '0;
      runnable_r <= '0;
    end else begin
      if (we) begin
        valid_r[wa] <= 1'b1;
      end
      if (ctrl.op == DP_WRITE && sa_ok) begin
        present_r[sa_idx]  <= pres_r;
        runnable_r[sa_idx] <= runb_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sa_r        <= slot_a;
      sb_r        <= slot_b;
      amt_r       <= ticket_amount;
      pres_r      <= entry_present;
      runb_r      <= entry_runnable;
      rnd_r       <= random_value;
      res_slot_r  <= '0;
      res_found_r <= 1'b0;
      res_moved_r <= '0;
    end else begin
      unique case (ctrl.op)
        DP_LOAD_SRC: begin
          src_r <= rdata;
          mv_r  <= mv_new;
        end
        DP_WR_SRC: begin
          // same slot on both sides sees the reduced count
          dst_r <= (sa_r == sb_r) ? src_left : rdata;
        end
        DP_WR_DST: begin
          res_moved_r <= AMOUNT_W'(mv_r);
        end
        DP_SCAN_INIT: begin
          idx_r <= '0;
          acc_r <= '0;
        end
        DP_SUM: begin
          acc_r <= run_new;
          idx_r <= next_idx;
        end
        DP_MOD_INIT: begin
          rem_r <= '0;
          bit_r <= BIT_W'(RND_W - 1);
        end
        DP_MOD_STEP: begin
          // one restoring step against the eligible total
          rem_r <= (shifted >= {1'b0, acc_r}) ? TOT_W'(shifted - {1'b0, acc_r})
                                              : TOT_W'(shifted);
          rnd_r <= rnd_r << 1;
          bit_r <= bit_r - 1'b1;
        end
        DP_PICK: begin
          acc_r <= run_new;
          idx_r <= next_idx;
          if (status.hit) begin
            res_slot_r  <= SLOT_W'(idx_r);
            res_found_r <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign winner_slot   = res_slot_r;
  assign winner_found  = res_found_r;
  assign moved_tickets = res_moved_r;

endmodule

[rtl/lottery_ticket_arbiter_unit.sv]
// top level of the lottery ticket arbiter: sequencer plus datapath
//
// Command port: a transaction is taken at a clock edge with start high and busy
// low; in_operation picks write entry, transfer tickets or draw winner, and the
// other in_ ports carry its operands.
// Result port: every transaction gives one result, shown for one cycle with
// out_valid high, in the same cycle that busy falls; the receiver cannot stall it.
// Steps of each operation, run while busy is high:
//   write entry        one table write
//   transfer           reads and writes source and destination (ends early on a
//                      bad slot or an empty source)
//   draw               a summing pass over the table, a 31-step bit-serial
//                      modulo, then a picking pass that stops at the winner; it
//                      ends after the summing pass with no eligible tickets; the
//                      single table read port sets one slot per cycle in both passes
//   unused operation   ends with no effect
// A new transaction can be started in the cycle the result is shown.
// Reset: synchronous, active low; the table reads as empty at once through
// per-slot valid flags, so no clearing pass is needed.
module lottery_ticket_arbiter_unit
  import lta_pkg::*;
#(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int TICKET_BITS = TICKET_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_operation,
  input  logic [SLOT_W-1:0]   in_slot_a,
  input  logic [SLOT_W-1:0]   in_slot_b,
  input  logic [AMOUNT_W-1:0] in_ticket_amount,
  input  logic                in_entry_present,
  input  logic                in_entry_runnable,
  input  logic [RND_W-1:0]    in_random_value,
  output logic                out_valid,
  output logic [SLOT_W-1:0]   out_winner_slot,
  output logic                out_winner_found,
  output logic [AMOUNT_W-1:0] out_moved_tickets
);

  ucode_t  ctrl;
  status_t status;
  logic    accept;

  assign accept = start && !busy;

  lta_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .operation (in_operation),
    .status    (status),
    .ctrl      (ctrl),
    .busy      (busy),
    .done      (out_valid)
  );

  lta_datapath #(
    .SLOTS       (SLOTS),
    .TICKET_BITS (TICKET_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .slot_a         (in_slot_a),
    .slot_b         (in_slot_b),
    .ticket_amount  (in_ticket_amount),
    .entry_present  (in_entry_present),
    .entry_runnable (in_entry_runnable),
    .random_value   (in_random_value),
    .ctrl           (ctrl),
    .status         (status),
    .winner_slot    (out_winner_slot),
    .winner_found   (out_winner_found),
    .moved_tickets  (out_moved_tickets)
  );

`ifndef NO_ASSERTIONS
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted transaction did not raise busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result strobe outside the end of a transaction");

  a_draw_moves_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_winner_found |-> out_moved_tickets == '0)
    else $error("draw result carries moved tickets");

  a_no_winner_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_winner_found |-> out_winner_slot == '0)
    else $error("winner slot set without a winner");
`endif

endmodule

[bench/lta_outcome_checker.sv]
// outcome checker for the lottery ticket arbiter: keeps a shadow ticket table and compares results
`timescale 1ns / 1ps

module lta_outcome_checker
  import lta_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic [1:0]          in_operation,
  input  logic [SLOT_W-1:0]   in_slot_a,
  input  logic [SLOT_W-1:0]   in_slot_b,
  input  logic [AMOUNT_W-1:0] in_ticket_amount,
  input  logic                in_entry_present,
  input  logic                in_entry_runnable,
  input  logic [RND_W-1:0]    in_random_value,
  input  logic                out_valid,
  input  logic [SLOT_W-1:0]   out_winner_slot,
  input  logic                out_winner_found,
  input  logic [AMOUNT_W-1:0] out_moved_tickets,
  output int                  failures,
  output int                  outstanding
);

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic                found;
    logic [AMOUNT_W-1:0] moved;
  } outcome_t;

  localparam logic [TICKET_BITS_DEF-1:0] TICKET_CAP = '1;

  logic [TICKET_BITS_DEF-1:0] tickets [SLOTS_DEF];
  logic                       present_bits [SLOTS_DEF];
  logic                       runnable_bits [SLOTS_DEF];
  outcome_t                   pending_outcomes [$];

  function automatic outcome_t apply_command(
    input logic [1:0]          op,
    input logic [SLOT_W-1:0]   sa,
    input logic [SLOT_W-1:0]   sb,
    input logic [AMOUNT_W-1:0] amount,
    input logic                pres,
    input logic                runb,
    input logic [RND_W-1:0]    rnd
  );
    outcome_t                   res;
    logic [TICKET_BITS_DEF-1:0] src;
    logic [TICKET_BITS_DEF-1:0] mv;
    logic [TICKET_BITS_DEF:0]   sum;
    logic [31:0]                total;
    logic [31:0]                running;
    logic [31:0]                draw;
    res = '0;
    total = '0;
    running = '0;
    case (op)
      OP_WRITE: begin
        tickets[sa] = amount[TICKET_BITS_DEF-1:0];
        present_bits[sa] = pres;
        runnable_bits[sa] = runb;
      end
      OP_TRANSFER: begin
        src = tickets[sa];
        if (src != '0) begin
          // an oversized request leaves one ticket behind
          mv = (amount > src) ? src - 1'b1 : amount;
          tickets[sa] = src - mv;
          // destination read after the source write, so same slot ends unchanged
          sum = {1'b0, tickets[sb]} + mv;
          tickets[sb] = sum[TICKET_BITS_DEF] ? TICKET_CAP : sum[TICKET_BITS_DEF-1:0];
          res.moved = mv;
        end
      end
      OP_DRAW: begin
        for (int s = 0; s < SLOTS_DEF; s++)
          if (present_bits[s] && runnable_bits[s]) total += tickets[s];
        if (total != '0) begin
          draw = {1'b0, rnd} % total;
          for (int s = 0; s < SLOTS_DEF; s++)
            if (!res.found && present_bits[s] && runnable_bits[s]) begin
              running += tickets[s];
              if (draw < running) begin
                res.found = 1'b1;
                res.slot = SLOT_W'(s);
              end
            end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    failures++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      for (int s = 0; s < SLOTS_DEF; s++) begin
        tickets[s] = '0;
        present_bits[s] = 1'b0;
        runnable_bits[s] = 1'b0;
      end
      pending_outcomes.delete();
      failures = 0;
    end else begin
      if (out_valid) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch("result with no transaction pending");
        end else begin
          want = pending_outcomes.pop_front();
          if (out_winner_slot !== want.slot)
            report_mismatch($sformatf("winner_slot got %0d expected %0d",
                                      out_winner_slot, want.slot));
          if (out_winner_found !== want.found)
            report_mismatch($sformatf("winner_found got %0d expected %0d",
                                      out_winner_found, want.found));
          if (out_moved_tickets !== want.moved)
            report_mismatch($sformatf("moved_tickets got %0d expected %0d",
                                      out_moved_tickets, want.moved));
        end
      end
      if (start && !busy)
        pending_outcomes.push_back(apply_command(in_operation, in_slot_a, in_slot_b,
                                                 in_ticket_amount, in_entry_present,
                                                 in_entry_runnable, in_random_value));
    end
    outstanding = pending_outcomes.size();
  end

endmodule

[bench/tb_lottery_ticket_arbiter_unit.sv]
// top of the lottery ticket arbiter testbench: clock, reset, command stimulus and verdict
`timescale 1ns / 1ps

module tb_lottery_ticket_arbiter_unit
  import lta_pkg::*;
;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         DRAIN_CYCLES = 80;
  localparam int         PHASE_ITEMS  = 112;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [1:0]          in_operation;
  logic [SLOT_W-1:0]   in_slot_a;
  logic [SLOT_W-1:0]   in_slot_b;
  logic [AMOUNT_W-1:0] in_ticket_amount;
  logic                in_entry_present;
  logic                in_entry_runnable;
  logic [RND_W-1:0]    in_random_value;
  logic                out_valid;
  logic [SLOT_W-1:0]   out_winner_slot;
  logic                out_winner_found;
  logic [AMOUNT_W-1:0] out_moved_tickets;
  int                  failures;
  int                  outstanding;
  int                  idle_pct;
  int                  phase_idle [4] = '{0, 84, 0, 38};

  lottery_ticket_arbiter_unit dut (.*);

  lta_outcome_checker outcome_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL lottery_ticket_arbiter_unit");
    $finish;
  end

  // returns at the edge where the transaction is taken
  task automatic issue_command(
    input logic [1:0]          op,
    input logic [SLOT_W-1:0]   sa,
    input logic [SLOT_W-1:0]   sb,
    input logic [AMOUNT_W-1:0] amount,
    input logic                pres,
    input logic                runb,
    input logic [RND_W-1:0]    rnd
  );
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start             <= 1'b1;
    in_operation      <= op;
    in_slot_a         <= sa;
    in_slot_b         <= sb;
    in_ticket_amount  <= amount;
    in_entry_present  <= pres;
    in_entry_runnable <= runb;
    in_random_value   <= rnd;
    do @(posedge clk); while (busy);
  endtask

  task automatic random_command();
    logic [1:0]          op;
    logic [SLOT_W-1:0]   sa;
    logic [SLOT_W-1:0]   sb;
    logic [AMOUNT_W-1:0] amount;
    logic                pres;
    logic                runb;
    logic [RND_W-1:0]    rnd;
    int                  pick;
    int                  kind;
    // unused fields still carry noise
    pick   = $urandom_range(99);
    kind   = $urandom_range(9);
    sa     = SLOT_W'($urandom);
    sb     = SLOT_W'($urandom);
    amount = AMOUNT_W'($urandom);
    pres   = 1'($urandom);
    runb   = 1'($urandom);
    rnd    = RND_W'($urandom);
    if (pick < 38) begin
      op = OP_WRITE;
      pres = ($urandom_range(3) != 0);
      runb = ($urandom_range(3) != 0);
      if (kind < 5) amount = AMOUNT_W'($urandom_range(40));
      else if (kind == 5) amount = '0;
      else if (kind == 8) amount = 16'hFFFF - AMOUNT_W'($urandom_range(63));
      else if (kind == 9) amount = 16'hFFFF;
    end else if (pick < 68) begin
      op = OP_TRANSFER;
      if (kind < 6) amount = AMOUNT_W'($urandom_range(48));
      else if (kind == 6) amount = '0;
      else if (kind == 8) amount = 16'hFFFF;
      else if (kind == 9) amount = AMOUNT_W'($urandom_range(3, 1));
    end else if (pick < 95) begin
      op = OP_DRAW;
      if (kind == 4 || kind == 5) rnd = RND_W'($urandom_range(200));
      else if (kind == 6) rnd = 31'h7FFFFFFF - RND_W'($urandom_range(1000));
      else if (kind == 7) rnd = '0;
    end else begin
      op = OP_UNUSED;
    end
    issue_command(op, sa, sb, amount, pres, runb, rnd);
  endtask

  initial begin
    rst_n             = 1'b0;
    start             = 1'b0;
    in_operation      = OP_WRITE;
    in_slot_a         = '0;
    in_slot_b         = '0;
    in_ticket_amount  = '0;
    in_entry_present  = 1'b0;
    in_entry_runnable = 1'b0;
    in_random_value   = '0;
    idle_pct          = 38;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // empty table: no winner, empty source, unused operation
    issue_command(OP_DRAW, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0, 31'h7FFFFFFF);
    issue_command(OP_UNUSED, 4'd15, 4'd15, 16'hFFFF, 1'b1, 1'b1, 31'h7FFFFFFF);
    issue_command(OP_TRANSFER, 4'd0, 4'd1, 16'd5, 1'b0, 1'b0, 31'd0);
    // eligible and ineligible entries
    issue_command(OP_WRITE, 4'd0, 4'd0, 16'hFFFF, 1'b1, 1'b1, 31'd0);
    issue_command(OP_WRITE, 4'd15, 4'd0, 16'd1, 1'b1, 1'b1, 31'd0);
    issue_command(OP_WRITE, 4'd7, 4'd0, 16'd100, 1'b1, 1'b0, 31'd0);
    issue_command(OP_WRITE, 4'd8, 4'd0, 16'd200, 1'b0, 1'b1, 31'd0);
    // draws at the low end, on the last ticket boundary and at the top of the word
    issue_command(OP_DRAW, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0, 31'd0);
    issue_command(OP_DRAW, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0, 31'd65534);
    issue_command(OP_DRAW, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0, 31'd65535);
    issue_command(OP_DRAW, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0, 31'h7FFFFFFF);
    // destination saturates, then the source is empty
    issue_command(OP_TRANSFER, 4'd15, 4'd0, 16'd1, 1'b0, 1'b0, 31'd0);
    issue_command(OP_TRANSFER, 4'd15, 4'd0, 16'd1, 1'b0, 1'b0, 31'd0);
    // oversized requests
    issue_command(OP_WRITE, 4'd3, 4'd0, 16'd10, 1'b1, 1'b1, 31'd0);
    issue_command(OP_TRANSFER, 4'd3, 4'd4, 16'd11, 1'b0, 1'b0, 31'd0);
    issue_command(OP_TRANSFER, 4'd3, 4'd4, 16'd5, 1'b0, 1'b0, 31'd0);
    // same slot on both sides, zero request, whole count moved
    issue_command(OP_TRANSFER, 4'd3, 4'd3, 16'd1, 1'b0, 1'b0, 31'd0);
    issue_command(OP_TRANSFER, 4'd0, 4'd15, 16'd0, 1'b0, 1'b0, 31'd0);
    issue_command(OP_TRANSFER, 4'd0, 4'd15, 16'hFFFF, 1'b0, 1'b0, 31'd0);
    issue_command(OP_WRITE, 4'd4, 4'd0, 16'd9, 1'b1, 1'b1, 31'd0);
    issue_command(OP_DRAW, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0, 31'd65535);
    issue_command(OP_WRITE, 4'd15, 4'd0, 16'hFFFF, 1'b0, 1'b0, 31'd0);
    issue_command(OP_DRAW, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0, 31'h7FFFFFFF);

    foreach (phase_idle[p]) begin
      idle_pct = phase_idle[p];
      repeat (PHASE_ITEMS) random_command();
    end
    start <= 1'b0;

    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && outstanding == 0)
      $display("PASS lottery_ticket_arbiter_unit");
    else
      $display("FAIL lottery_ticket_arbiter_unit");
    $finish;
  end

endmodule
